// ----- rtl/sjf_pkg.sv -----
// ----------------------------------------------------------------------------
// sjf_pkg: shared types and constants for the shortest-job-first scheduler
// Job slot, cell control, transaction payloads and time limits.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int ID_W       = 8;
  localparam int BURST_W    = 16;
  localparam int TIME_W     = 20;
  localparam int MAX_JOBS_D = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } ctrl_t;

  typedef struct packed {
    logic [ID_W-1:0]    proc_id;
    logic [BURST_W-1:0] burst;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] job_burst;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  stop_time;
    logic               final_res;
  } out_t;

endpackage

// ----- rtl/shortest_job_first_schedule_core.sv -----
// ----------------------------------------------------------------------------
// shortest_job_first_schedule_core: non-preemptive shortest-job-first scheduler
// Loads one job per cycle into a chain of sorted cells; on the last job emits
// the schedule from the head of the chain, one result per cycle while out_ready
// is high. in_ready is high while loading and low during the emit pass.
// Reset: all cells empty, no clearing pass; results register empty.
// ----------------------------------------------------------------------------
module shortest_job_first_schedule_core #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_D
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sjf_pkg::in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output sjf_pkg::out_t out_data
);
  import sjf_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  slot_t              cell_q [MAX_JOBS];
  logic               gt_q   [MAX_JOBS];
  slot_t              new_job;
  slot_t              head_slot;
  ctrl_t              ctrl;
  logic               in_acc;
  logic               full;
  logic               emit_go;
  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  stop;
  logic [TIME_W-1:0]  t_r;
  logic               out_valid_r;
  out_t               out_r;
  out_t               out_d;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign full      = cell_q[MAX_JOBS-1].valid;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign ctrl.ins   = in_acc && !full;
  assign ctrl.shift = emit_go;

  assign new_job.valid = 1'b1;
  assign new_job.id    = in_data.proc_id;
  assign new_job.burst = in_data.burst;

  assign head_slot.valid = 1'b1;
  assign head_slot.id    = '0;
  assign head_slot.burst = '0;

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    slot_t prev_s;
    logic  prev_g;
    slot_t next_s;
    if (i == 0) begin : g_head
      assign prev_s = head_slot;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_s = cell_q[i-1];
      assign prev_g = gt_q[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_link
      assign next_s = cell_q[i+1];
    end
    sjf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_job   (new_job),
      .prev_slot (prev_s),
      .prev_gt   (prev_g),
      .next_slot (next_s),
      .slot      (cell_q[i]),
      .gt        (gt_q[i])
    );
  end

  assign sum  = {1'b0, t_r} + {{(TIME_W + 1 - BURST_W){1'b0}}, cell_q[0].burst};
  assign stop = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  assign out_d.job_id     = cell_q[0].id;
  assign out_d.job_burst  = cell_q[0].burst;
  assign out_d.start_time = t_r;
  assign out_d.stop_time  = stop;
  assign out_d.final_res  = !cell_q[1].valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go && out_d.final_res) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
        t_r         <= out_d.final_res ? '0 : stop;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_r <= out_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    cell_q[1].valid |-> cell_q[0].valid)
    else $error("job chain has a gap at the head");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> cell_q[0].valid)
    else $error("emit pass with empty chain");

  a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && out_d.final_res) |=> (state_r == ST_LOAD) && !cell_q[0].valid)
    else $error("final result left jobs behind");

  a_time_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (t_r == '0))
    else $error("time accumulator not cleared while loading");

  a_stop_order: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> (stop >= t_r))
    else $error("completion time before start time");

endmodule

// ----- rtl/sjf_cell.sv -----
// ----------------------------------------------------------------------------
// sjf_cell: one slot of the sorted job chain
// Holds one job; on insert keeps, takes its left neighbour or takes the new
// job; on shift takes its right neighbour.
// ----------------------------------------------------------------------------
module sjf_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  sjf_pkg::ctrl_t ctrl,
  input  sjf_pkg::slot_t new_job,
  input  sjf_pkg::slot_t prev_slot,
  input  logic          prev_gt,
  input  sjf_pkg::slot_t next_slot,
  output sjf_pkg::slot_t slot,
  output logic          gt
);
  import sjf_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;

  assign slot = slot_r;
  assign gt   = slot_r.valid && (slot_r.burst > new_job.burst);

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.shift) begin
      slot_nxt = next_slot;
    end else if (ctrl.ins && (gt || !slot_r.valid)) begin
      if (prev_gt) begin
        slot_nxt = prev_slot;
      end else if (prev_slot.valid) begin
        slot_nxt = new_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

// ----- tb/tb_shortest_job_first_schedule_core.sv -----
// ----------------------------------------------------------------------------
// tb_shortest_job_first_schedule_core: self-checking bench for the SJF core
// Loads job sets through the valid/ready input channel and checks every
// scheduled result against a sorted-insertion model of the job store.
// Directed sets cover zero and maximum bursts, ties kept in arrival order and
// a full store that drops further jobs. Random sets follow, with random gaps
// on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_shortest_job_first_schedule_core;
  import sjf_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int JOB_TARGET  = 210;

  class job_schedule_board;
    logic [ID_W-1:0]    ids    [MAX_JOBS_D];
    logic [BURST_W-1:0] bursts [MAX_JOBS_D];
    int                 count;
    out_t               sched_q[$];
    int                 mismatches;

    function void note_job(in_t job);
      int               pos;
      logic [TIME_W:0]  t;
      logic [TIME_W:0]  stop;
      out_t             r;
      if (count < MAX_JOBS_D) begin
        pos = count;
        while (pos > 0 && bursts[pos-1] > job.burst) begin
          bursts[pos] = bursts[pos-1];
          ids[pos]    = ids[pos-1];
          pos--;
        end
        bursts[pos] = job.burst;
        ids[pos]    = job.proc_id;
        count++;
      end
      if (job.last) begin
        t = '0;
        for (int k = 0; k < count; k++) begin
          stop = t + bursts[k];
          if (stop > TIME_MAX) stop = TIME_MAX;
          r.job_id     = ids[k];
          r.job_burst  = bursts[k];
          r.start_time = t[TIME_W-1:0];
          r.stop_time  = stop[TIME_W-1:0];
          r.final_res  = (k + 1 == count);
          sched_q.push_back(r);
          t = stop;
        end
        count = 0;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (sched_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: id=%0d burst=%0d start=%0d stop=%0d final=%0d",
                   got.job_id, got.job_burst, got.start_time, got.stop_time,
                   got.final_res);
        return;
      end
      exp = sched_q.pop_front();
      if (got.job_id !== exp.job_id || got.job_burst !== exp.job_burst ||
          got.start_time !== exp.start_time || got.stop_time !== exp.stop_time ||
          got.final_res !== exp.final_res) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result mismatch: expected id=%0d burst=%0d start=%0d stop=%0d final=%0d",
                 exp.job_id, exp.job_burst, exp.start_time, exp.stop_time,
                 exp.final_res);
          $display(", got id=%0d burst=%0d start=%0d stop=%0d final=%0d",
                   got.job_id, got.job_burst, got.start_time, got.stop_time,
                   got.final_res);
        end
      end
    endfunction

    function int pending();
      return sched_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  job_schedule_board sb = new();
  int sender_mode = 0;
  int ready_mode  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  int jobs_sent   = 0;

  shortest_job_first_schedule_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_job(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (ready_mode != 0 &&
                 $urandom_range(0, 99) < ((ready_mode == 3) ? 30 : 12)) begin
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                              : $urandom_range(9, 39);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_mode == 0 || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BURST_W-1:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return BURST_W'($urandom_range(0, 65535));
    if (r < 80) return BURST_W'($urandom_range(0, 7));
    if (r < 87) return '0;
    if (r < 94) return '1;
    return BURST_W'($urandom_range(65500, 65535));
  endfunction

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 5);
    if (r < 88) return $urandom_range(6, MAX_JOBS_D);
    return $urandom_range(MAX_JOBS_D + 1, MAX_JOBS_D + 4);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_job(input in_t job, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= job;
    do @(posedge clk); while (!in_ready);
    jobs_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_set();
    int   n;
    in_t  job;
    n = pick_set_size();
    for (int i = 0; i < n; i++) begin
      job.proc_id = ID_W'($urandom_range(0, 255));
      job.burst   = pick_burst();
      job.last    = (i == n - 1);
      send_job(job, pick_gap());
    end
  endtask

  initial begin
    in_t job;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single job with zero burst and zero identifier
    job = '{proc_id: '0, burst: '0, last: 1'b1};
    send_job(job, 0);

    // ties at the maximum burst keep arrival order; zero burst goes first
    send_job('{proc_id: 8'd255, burst: 16'hFFFF, last: 1'b0}, 0);
    send_job('{proc_id: 8'd7,   burst: 16'hFFFF, last: 1'b0}, 0);
    send_job('{proc_id: 8'd3,   burst: 16'h0000, last: 1'b0}, 0);
    send_job('{proc_id: 8'd128, burst: 16'hFFFF, last: 1'b0}, 0);
    send_job('{proc_id: 8'd90,  burst: 16'h0001, last: 1'b1}, 0);

    // fill the store, then drop one plain job and one carrying the last mark
    for (int i = 0; i < MAX_JOBS_D; i++) begin
      job.proc_id = ID_W'(8'hF0 + i);
      job.burst   = (i < 8) ? 16'hFFFF : BURST_W'(16'hFFFF - (i % 4));
      job.last    = 1'b0;
      send_job(job, 0);
    end
    send_job('{proc_id: 8'h55, burst: 16'h0000, last: 1'b0}, 0);
    send_job('{proc_id: 8'hAA, burst: 16'h0005, last: 1'b1}, 0);
    wait_drained();

    while (jobs_sent < JOB_TARGET) begin
      sender_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      ready_mode  = $urandom_range(0, 3);
      send_random_set();
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sjf_pkg.sv
rtl/sjf_cell.sv
rtl/shortest_job_first_schedule_core.sv
tb/tb_shortest_job_first_schedule_core.sv
